@@ src/bcc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants of the bilayer crossing counter
// Field types of the request and result, the token that walks the level
// cells, and the memory and clear commands between the top level and cells.
// ----------------------------------------------------------------------------
package bcc_pkg;

    localparam int SOUTH_MAX = 1024;
    localparam int KEY_W     = $clog2(SOUTH_MAX);          // leaf index bits
    localparam int LEVELS    = KEY_W + 1;                  // tree levels
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int ROW_W     = KEY_W - 1;                  // pair-row index bits
    localparam int ROWS_MAX  = SOUTH_MAX / 2;
    localparam int ENTRY_W   = 32;
    localparam int ROW_DW    = 2 * ENTRY_W;
    localparam int RSUM_W    = ENTRY_W + $clog2(LEVELS);
    localparam int CNT_W     = 11;
    localparam int POS_W     = 10;
    localparam int WGT_W     = 16;
    localparam int TOTAL_W   = 48;

    localparam logic MODE_CLEAR = 1'b0;
    localparam logic MODE_EDGE  = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [POS_W-1:0] position;
        logic [WGT_W-1:0] weight;
    } t_req;

    typedef struct packed {
        logic [TOTAL_W-1:0] crossings;
        logic [ENTRY_W-1:0] right_weight;
    } t_result;

    // One edge on its way from the leaf level to the root.
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  k;       // node index within the current level
        logic [WGT_W-1:0]  w;
        logic [LVL_W-1:0]  d;       // leaf level of this edge
        logic [LVL_W-1:0]  lvl;     // level of the cell that takes it next
        logic [RSUM_W-1:0] rsum;
    } t_tok;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] addr;
    } t_clr;

    typedef struct packed {
        logic              wr_en;
        logic [ROW_W-1:0]  wr_addr;
        logic [ROW_DW-1:0] wr_data;
        logic [ROW_W-1:0]  rd_addr;
    } t_ram_cmd;

endpackage
`default_nettype wire

@@ src/bcc_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_ram: simple dual-port RAM with registered read
// One write port and one read port; holds one tree level as rows of pairs.
// ----------------------------------------------------------------------------
module bcc_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ src/bcc_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_cell: one level of the accumulator tree
// Adds the edge weight to its node, picks up the right sibling's weight and
// hands the token to the parent level in the cycle after it arrives.
// ----------------------------------------------------------------------------
module bcc_cell import bcc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_tok              i_tok,
    output t_tok                   o_tok,
    input  wire t_clr              i_clr,
    output t_ram_cmd               o_ram,
    input  wire logic [ROW_DW-1:0] i_rd_data
);

    t_tok              r_tok;
    logic              act;
    logic              odd;
    logic [ENTRY_W-1:0] own;
    logic [ENTRY_W-1:0] sib;
    logic [ENTRY_W:0]   own_sum;
    logic [ENTRY_W-1:0] own_new;
    logic               sib_add;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
        r_tok.k    <= i_tok.k;
        r_tok.w    <= i_tok.w;
        r_tok.d    <= i_tok.d;
        r_tok.lvl  <= i_tok.lvl;
        r_tok.rsum <= i_tok.rsum;
    end

    // Levels below the edge's leaf level let the token pass untouched.
    assign act     = r_tok.valid && (r_tok.lvl <= r_tok.d);
    assign odd     = r_tok.k[0];
    assign own     = odd ? i_rd_data[ROW_DW-1:ENTRY_W] : i_rd_data[ENTRY_W-1:0];
    assign sib     = i_rd_data[ROW_DW-1:ENTRY_W];
    assign own_sum = {1'b0, own} + (ENTRY_W+1)'(r_tok.w);
    assign own_new = own_sum[ENTRY_W] ? '1 : own_sum[ENTRY_W-1:0];
    // A left child below the root picks up its right sibling.
    assign sib_add = act && (r_tok.lvl != '0) && !odd;

    always_comb begin
        o_tok       = r_tok;
        o_tok.lvl   = r_tok.lvl - LVL_W'(1);
        if (act) begin
            o_tok.k = r_tok.k >> 1;
        end
        if (sib_add) begin
            o_tok.rsum = r_tok.rsum + RSUM_W'(sib);
        end
    end

    always_comb begin
        o_ram.rd_addr = i_tok.k[KEY_W-1:1];
        if (i_clr.en) begin
            o_ram.wr_en   = 1'b1;
            o_ram.wr_addr = i_clr.addr;
            o_ram.wr_data = '0;
        end else begin
            o_ram.wr_en   = act;
            o_ram.wr_addr = r_tok.k[KEY_W-1:1];
            o_ram.wr_data = odd ? {own_new, i_rd_data[ENTRY_W-1:0]}
                                : {i_rd_data[ROW_DW-1:ENTRY_W], own_new};
        end
    end

endmodule
`default_nettype wire

@@ src/bilayer_cross_counter_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bilayer_cross_counter_top: weighted bilayer crossing counter
// An edge request walks a chain of eleven level cells, deepest level first, each
// cell registering it in turn; then a multiply state and an accumulate state.
// Edge request: busy from acceptance until the result strobe.
// Clear request: a zeroing pass over all 512 rows of the level memories, then the
// result strobe; the same pass runs after reset, with no result.
// Reset is synchronous, active low; results cannot be stalled.
// ----------------------------------------------------------------------------
module bilayer_cross_counter_top import bcc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_busy,
    input  wire t_req             i_req,
    output logic                  o_done,
    output t_result               o_result,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CNT_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_WALK,
        S_MUL,
        S_ACC
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_south_cnt;
    logic [ROW_W-1:0]   r_clr_cnt;
    logic               r_clr_report;
    t_tok               r_inj;
    logic [WGT_W-1:0]   r_w;
    logic [ENTRY_W-1:0] r_rsum;
    logic [TOTAL_W-1:0] r_prod;
    logic [TOTAL_W-1:0] r_total;
    logic               r_done;
    t_result            r_result;

    logic [CNT_W-1:0]   n_eff;
    logic [LVL_W-1:0]   depth;
    logic [KEY_W-1:0]   pos_eff;
    logic               accept;
    logic [TOTAL_W-1:0] mul_full;
    logic [TOTAL_W:0]   tot_sum;
    logic [TOTAL_W-1:0] n_total;
    logic [ENTRY_W-1:0] rsum_sat;
    t_clr               clr;

    t_tok               tok [LEVELS+1];
    t_ram_cmd           ram [LEVELS];
    logic [ROW_DW-1:0]  rd_data [LEVELS];

    assign accept      = i_start && (r_state == S_IDLE);
    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_result    = r_result;

    always_comb begin
        if (r_south_cnt == '0) begin
            n_eff = CNT_W'(1);
        end else if (r_south_cnt > CNT_W'(SOUTH_MAX)) begin
            n_eff = CNT_W'(SOUTH_MAX);
        end else begin
            n_eff = r_south_cnt;
        end
    end

    // Leaf level: smallest power of two not below the south count.
    always_comb begin
        depth = '0;
        for (int j = LEVELS - 1; j >= 0; j--) begin
            if (((CNT_W+1)'(1) << j) >= {1'b0, n_eff}) begin
                depth = LVL_W'(j);
            end
        end
    end

    assign pos_eff = (CNT_W'(i_req.position) >= n_eff) ? '0 : KEY_W'(i_req.position);

    assign rsum_sat = (tok[LEVELS].rsum > RSUM_W'({ENTRY_W{1'b1}}))
                      ? '1 : tok[LEVELS].rsum[ENTRY_W-1:0];
    assign mul_full = TOTAL_W'(r_w) * TOTAL_W'(r_rsum);
    assign tot_sum  = {1'b0, r_total} + {1'b0, r_prod};
    assign n_total  = tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];

    assign clr.en   = (r_state == S_CLEAR);
    assign clr.addr = r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_south_cnt  <= CNT_W'(1);
            r_clr_cnt    <= '0;
            r_clr_report <= 1'b0;
            r_inj.valid  <= 1'b0;
            r_done       <= 1'b0;
            r_total      <= '0;
        end else begin
            r_inj.valid <= 1'b0;
            r_done      <= 1'b0;
            if (i_cfg_valid) begin
                r_south_cnt <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_req.mode == MODE_CLEAR) begin
                            r_state      <= S_CLEAR;
                            r_clr_cnt    <= '0;
                            r_clr_report <= 1'b1;
                            r_total      <= '0;
                        end else begin
                            r_state     <= S_WALK;
                            r_inj.valid <= 1'b1;
                            r_inj.k     <= pos_eff;
                            r_inj.w     <= i_req.weight;
                            r_inj.d     <= depth;
                            r_inj.lvl   <= LVL_W'(LEVELS - 1);
                            r_inj.rsum  <= '0;
                            r_w         <= i_req.weight;
                        end
                    end
                end
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + ROW_W'(1);
                    if (&r_clr_cnt) begin
                        r_state <= S_IDLE;
                        if (r_clr_report) begin
                            r_done                <= 1'b1;
                            r_result.crossings    <= '0;
                            r_result.right_weight <= '0;
                        end
                    end
                end
                S_WALK: begin
                    if (tok[LEVELS].valid) begin
                        r_rsum  <= rsum_sat;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= mul_full;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_total               <= n_total;
                    r_done                <= 1'b1;
                    r_result.crossings    <= n_total;
                    r_result.right_weight <= r_rsum;
                    r_state               <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign tok[0] = r_inj;

    // Chain position i holds tree level LEVELS-1-i; level L of 2 or more keeps 2^L
    // entries as rows of left/right pairs, levels 0 and 1 two rows each.
    for (genvar i = 0; i < LEVELS; i++) begin : g_level
        localparam int LVL   = LEVELS - 1 - i;
        localparam int DEPTH = (LVL < 2) ? 2 : (1 << (LVL - 1));
        localparam int AW    = $clog2(DEPTH);

        bcc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tok     (tok[i]),
            .o_tok     (tok[i+1]),
            .i_clr     (clr),
            .o_ram     (ram[i]),
            .i_rd_data (rd_data[i])
        );

        bcc_ram #(
            .DEPTH (DEPTH),
            .WIDTH (ROW_DW)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram[i].wr_en),
            .i_waddr (ram[i].wr_addr[AW-1:0]),
            .i_wdata (ram[i].wr_data),
            .i_raddr (ram[i].rd_addr[AW-1:0]),
            .o_rdata (rd_data[i])
        );
    end

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe lasted more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted request did not raise busy");

    a_token_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok[LEVELS].valid |-> (r_state == S_WALK))
        else $error("token left the root outside the walk phase");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_inj.valid)
        else $error("edge injected during the clearing pass");
`endif

endmodule
`default_nettype wire

@@ tb/bilayer_cross_counter_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bilayer_cross_counter_top_tb: self-checking bench for the crossing counter
// A queue of edge and clear requests feeds a clocked driver that idles at
// random. Each accepted request is run through a behavioral accumulator tree
// to predict the crossing total and right weight, which a clocked monitor
// compares with every result strobe. The south count is rewritten between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module bilayer_cross_counter_top_tb import bcc_pkg::*; ();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PCT     = 17;
    localparam int RANDOM_ITEMS = 1600;
    localparam int TAIL_CYCLES  = 40;
    localparam logic [63:0] ENTRY_CAP = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] TOTAL_CAP = 64'h0000_FFFF_FFFF_FFFF;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_start     = 1'b0;
    logic             o_busy;
    t_req             i_req       = '0;
    logic             o_done;
    t_result          o_result;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data  = '0;

    bilayer_cross_counter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Behavioral copy of the tree, the running total and the south count.
    logic [ENTRY_W-1:0] weight_tree [0:2*SOUTH_MAX-1];
    logic [TOTAL_W-1:0] cross_total = '0;
    logic [CNT_W-1:0]   south_count = 1;

    t_req        request_q[$];
    t_result     expected_totals_q[$];
    bit          steady         = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    function automatic int unsigned effective_count(logic [CNT_W-1:0] value);
        int unsigned n;
        n = 32'(value);
        if (n == 0) n = 1;
        if (n > SOUTH_MAX) n = SOUTH_MAX;
        return n;
    endfunction

    function automatic logic [ENTRY_W-1:0] add_clamped(logic [ENTRY_W-1:0] a,
                                                       logic [WGT_W-1:0] b);
        logic [ENTRY_W:0] s;
        s = {1'b0, a} + (ENTRY_W+1)'(b);
        return s[ENTRY_W] ? '1 : s[ENTRY_W-1:0];
    endfunction

    function automatic t_result count_crossings(t_req r);
        t_result     res;
        int unsigned n, base, pos, node;
        logic [63:0] right_sum, prod, room;
        res = '0;
        if (r.mode == MODE_CLEAR) begin
            foreach (weight_tree[i]) weight_tree[i] = '0;
            cross_total = '0;
        end else begin
            n = effective_count(south_count);
            base = 1;
            while (base < n) base = base << 1;
            pos = 32'(r.position);
            if (pos >= n) pos = 0;
            node = pos + base - 1;
            weight_tree[node] = add_clamped(weight_tree[node], r.weight);
            right_sum = '0;
            // An odd index is a left child, so its right sibling lies to the right.
            while (node > 0) begin
                if (node % 2 == 1) right_sum = right_sum + 64'(weight_tree[node + 1]);
                node = (node - 1) >> 1;
                weight_tree[node] = add_clamped(weight_tree[node], r.weight);
            end
            if (right_sum > ENTRY_CAP) right_sum = ENTRY_CAP;
            prod = right_sum * 64'(r.weight);
            room = TOTAL_CAP - 64'(cross_total);
            if (prod > room) cross_total = '1;
            else cross_total = cross_total + prod[TOTAL_W-1:0];
            res.crossings    = cross_total;
            res.right_weight = right_sum[ENTRY_W-1:0];
        end
        return res;
    endfunction

    // Driver: a request is taken when start is high and busy is low.
    always @(posedge i_clk) begin
        bit holding;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            holding = i_start;
            if (i_start && !o_busy) begin
                expected_totals_q.push_back(count_crossings(i_req));
                holding = 1'b0;
            end
            if (!holding) begin
                if (request_q.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    i_req   <= request_q.pop_front();
                    i_start <= 1'b1;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("cycle %0d: %s expected %0h, got %0h", cycle_count, what, want, got);
    endtask

    // Monitor: every strobe is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (expected_totals_q.size() == 0) begin
                flag_mismatch("unrequested result, crossings", '0,
                              64'(o_result.crossings));
            end else begin
                want = expected_totals_q.pop_front();
                if (o_result.crossings !== want.crossings)
                    flag_mismatch("crossings", 64'(want.crossings),
                                  64'(o_result.crossings));
                if (o_result.right_weight !== want.right_weight)
                    flag_mismatch("right_weight", 64'(want.right_weight),
                                  64'(o_result.right_weight));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_edge(input int unsigned pos, input int unsigned w);
        t_req r;
        r.mode     = MODE_EDGE;
        r.position = pos[POS_W-1:0];
        r.weight   = w[WGT_W-1:0];
        request_q.push_back(r);
    endtask

    task automatic push_clear(input int unsigned pos, input int unsigned w);
        t_req r;
        r.mode     = MODE_CLEAR;
        r.position = pos[POS_W-1:0];
        r.weight   = w[WGT_W-1:0];
        request_q.push_back(r);
    endtask

    function automatic int unsigned pick_weight();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll < 2) return $urandom_range(15);
        if (roll < 4) return 65535 - $urandom_range(15);
        return $urandom_range(65535);
    endfunction

    // Waits until every queued request has gone in and its result has come back.
    task automatic drain();
        @(negedge i_clk);
        while (request_q.size() > 0 || i_start || expected_totals_q.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        south_count = value;
        @(negedge i_clk);
    endtask

    initial begin
        int unsigned random_items, n_eff, pos, span, k, nodes;
        logic [CNT_W-1:0] count_choices [15];
        logic [CNT_W-1:0] cnt;

        count_choices = '{0, 1, 2, 3, 7, 64, 100, 511, 512, 513, 1000, 1023, 1024,
                          1025, 2047};
        foreach (weight_tree[i]) weight_tree[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: out-of-range positions, extreme weights, ignored fields of a
        // clear, south count of zero and above the maximum, and a count change
        // that leaves the tree uncleared.
        push_edge(0, 5);
        push_edge(1023, 65535);
        push_clear(1023, 65535);
        drain();
        write_count(1024);
        push_edge(1023, 65535);
        push_edge(0, 65535);
        push_edge(512, 1);
        push_edge(511, 65535);
        push_edge(1023, 0);
        push_edge(0, 0);
        drain();
        write_count(0);
        push_edge(0, 9);
        push_edge(700, 9);
        drain();
        write_count(2047);
        push_edge(1023, 100);
        push_edge(0, 100);
        push_clear(0, 0);
        drain();
        write_count(3);
        push_edge(2, 10);
        push_edge(3, 10);
        push_edge(0, 10);
        push_edge(1, 10);
        drain();

        // Long run of heavy edges placed right to left drives the total to its cap.
        steady = 1'b1;
        write_count(1024);
        push_clear(0, 0);
        for (int p = 1023; p >= 600; p--) push_edge(p, 65535);
        repeat (20) push_edge($urandom_range(1023), pick_weight());
        random_items = 445;
        drain();
        steady = 1'b0;

        // Random layers: runs of edges sorted by position within each north node.
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(3) == 0) cnt = CNT_W'($urandom_range(2047));
            else cnt = count_choices[$urandom_range(14)];
            write_count(cnt);
            n_eff = effective_count(cnt);
            span  = (n_eff > 4) ? n_eff / 4 : 1;
            if ($urandom_range(3) != 0) begin
                push_clear($urandom_range(1023), $urandom_range(65535));
                random_items++;
            end
            nodes = $urandom_range(6, 24);
            repeat (nodes) begin
                if ($urandom_range(99) < 15) begin
                    if ($urandom_range(19) == 0)
                        push_clear($urandom_range(1023), $urandom_range(65535));
                    else
                        push_edge($urandom_range(1023), pick_weight());
                    random_items++;
                end else begin
                    k   = $urandom_range(1, 8);
                    pos = $urandom_range(n_eff - 1);
                    repeat (k) begin
                        push_edge(pos, pick_weight());
                        pos = pos + $urandom_range(span);
                        if (pos >= n_eff) pos = n_eff - 1;
                    end
                    random_items += k;
                end
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_totals_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
